[hw/rtl/tcc_pkg.sv]
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package tcc_pkg;

  localparam logic [8:0] MaxColumns = 9'd256;
  localparam logic [7:0] MaxRows    = 8'd128;

  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChReturn    = 8'd13;
  localparam logic [7:0] ChBackspace = 8'd8;
  localparam logic [7:0] ChSpace     = 8'd32;

  localparam logic [1:0] RegColumnCount = 2'd0;
  localparam logic [1:0] RegRowCount    = 2'd1;
  localparam logic [1:0] RegForeground  = 2'd2;
  localparam logic [1:0] RegBackground  = 2'd3;

  localparam logic [8:0]  ColumnCountReset = 9'd80;
  localparam logic [7:0]  RowCountReset    = 8'd25;
  localparam logic [31:0] ForegroundReset  = 32'hffededed;
  localparam logic [31:0] BackgroundReset  = 32'hff233c67;

  typedef enum logic [2:0] {
    OP_TOGGLE,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_PRINT
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  glyph;
  } op_t;

  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_GLYPH  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_PRE,
    PH_GLYPH,
    PH_POST,
    PH_CURSOR
  } phase_e;

  typedef struct packed {
    logic [8:0]  column_count;
    logic [7:0]  row_count;
    logic [31:0] fg;
    logic [31:0] bg;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [31:0] color;
    logic        last;
  } draw_t;

  typedef struct packed {
    logic [7:0] first_col;
    logic [6:0] first_row;
    logic       first_fg;
    logic       only_first;
    logic       pre_scroll;
    logic       glyph_en;
    logic [7:0] glyph_col;
    logic [6:0] glyph_row;
    logic [7:0] glyph_code;
    logic       post_scroll;
    logic [7:0] end_col;
    logic [6:0] end_row;
  } plan_t;

endpackage

`default_nettype wire

[hw/rtl/tcc_cfg_regs.sv]
// APB-style configuration registers: grid size and colors.
// Depends on tcc_pkg.
`default_nettype none

module tcc_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcc_pkg::cfg_t     cfg_o
);
  import tcc_pkg::*;

  logic [1:0]  reg_idx;
  logic        wr_en;
  logic [8:0]  column_count_q;
  logic [7:0]  row_count_q;
  logic [31:0] fg_q;
  logic [31:0] bg_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= ColumnCountReset;
      row_count_q    <= RowCountReset;
      fg_q           <= ForegroundReset;
      bg_q           <= BackgroundReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegColumnCount: column_count_q <= pwdata[8:0];
        RegRowCount:    row_count_q    <= pwdata[7:0];
        RegForeground:  fg_q           <= pwdata;
        RegBackground:  bg_q           <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegColumnCount: prdata = {23'd0, column_count_q};
      RegRowCount:    prdata = {24'd0, row_count_q};
      RegForeground:  prdata = fg_q;
      RegBackground:  prdata = bg_q;
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.column_count = column_count_q;
  assign cfg_o.row_count    = row_count_q;
  assign cfg_o.fg           = fg_q;
  assign cfg_o.bg           = bg_q;

endmodule

`default_nettype wire

[hw/rtl/tcc_front.sv]
// Front end: takes input words and classifies them into cursor operations.
// Depends on tcc_pkg; feeds tcc_op_queue.
`default_nettype none

module tcc_front (
  input  wire logic             push,
  input  wire logic             mode_i,
  input  wire logic [7:0]       glyph_code_i,
  input  wire tcc_pkg::q_stat_t q_stat_i,
  output logic                  full,
  output logic                  q_wr_o,
  output tcc_pkg::op_t          q_op_o
);
  import tcc_pkg::*;

  assign full   = q_stat_i.full;
  assign q_wr_o = push & ~q_stat_i.full;

  always_comb begin
    q_op_o.glyph = glyph_code_i;
    if (mode_i) begin
      q_op_o.kind = OP_TOGGLE;
    end else if (glyph_code_i == ChNewline) begin
      q_op_o.kind = OP_NEWLINE;
    end else if (glyph_code_i == ChReturn) begin
      q_op_o.kind = OP_RETURN;
    end else if (glyph_code_i == ChBackspace) begin
      q_op_o.kind = OP_BACKSPACE;
    end else begin
      q_op_o.kind = OP_PRINT;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcc_op_queue.sv]
// Two-entry operation queue between front end and back end.
// Depends on tcc_pkg.
`default_nettype none

module tcc_op_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  wire tcc_pkg::op_t wr_op_i,
  input  wire logic         rd_i,
  output tcc_pkg::op_t      rd_op_o,
  output tcc_pkg::q_stat_t  stat_o
);
  import tcc_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign stat_o.empty = (count_q == CntW'(0));
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign do_wr = wr_i & ~stat_o.full;
  assign do_rd = rd_i & ~stat_o.empty;
  assign rd_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcc_back.sv]
// Back end: cursor state, per-operation command plan, command sequencer and
// output register. Depends on tcc_pkg; reads from tcc_op_queue.
`default_nettype none

module tcc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tcc_pkg::cfg_t    cfg_i,
  input  wire tcc_pkg::q_stat_t q_stat_i,
  input  wire tcc_pkg::op_t     q_op_i,
  output logic                  q_rd_o,
  input  wire logic             pop_i,
  output logic                  out_valid_o,
  output tcc_pkg::draw_t        draw_o
);
  import tcc_pkg::*;

  phase_e     phase_q, phase_d;
  plan_t      plan_q, plan_d;
  logic [7:0] cur_col_q, cur_col_d;
  logic [6:0] cur_row_q, cur_row_d;
  logic       shown_q, shown_d;
  logic       out_valid_q, out_valid_d;
  draw_t      out_q;

  logic [8:0] cols, cols_m1, x9, xw, xb, xe;
  logic [7:0] rows, rows_m1, y8, yw, yg, yb, ye_pre, ye;
  logic       wrap, pre, post;

  logic       out_free, busy, advance, load, cur_last;
  draw_t      cur_draw;
  phase_e     after_first, after_glyph;

  // clamp grid size to the supported range
  always_comb begin
    if (cfg_i.column_count == 9'd0) begin
      cols = 9'd1;
    end else if (cfg_i.column_count > MaxColumns) begin
      cols = MaxColumns;
    end else begin
      cols = cfg_i.column_count;
    end
    if (cfg_i.row_count == 8'd0) begin
      rows = 8'd1;
    end else if (cfg_i.row_count > MaxRows) begin
      rows = MaxRows;
    end else begin
      rows = cfg_i.row_count;
    end
  end

  assign cols_m1 = cols - 9'd1;
  assign rows_m1 = rows - 8'd1;
  assign x9      = {1'b0, cur_col_q};
  assign y8      = {1'b0, cur_row_q};

  // printable: wrap, then scroll before the glyph if it fell off the bottom
  assign wrap = (x9 >= cols_m1);
  assign xw   = wrap ? 9'd0 : x9;
  assign yw   = wrap ? y8 + 8'd1 : y8;
  assign pre  = (yw >= rows);
  assign yg   = pre ? rows_m1 : yw;

  // backspace: step back, to the end of the previous row at column zero
  always_comb begin
    xb = x9;
    yb = y8;
    if (x9 != 9'd0) begin
      xb = x9 - 9'd1;
    end else if (y8 != 8'd0) begin
      yb = y8 - 8'd1;
      xb = cols_m1;
    end
  end

  always_comb begin
    case (q_op_i.kind)
      OP_NEWLINE: begin
        xe     = 9'd0;
        ye_pre = y8 + 8'd1;
      end
      OP_RETURN: begin
        xe     = 9'd0;
        ye_pre = y8;
      end
      OP_BACKSPACE: begin
        xe     = xb;
        ye_pre = yb;
      end
      OP_PRINT: begin
        xe     = xw + 9'd1;
        ye_pre = yg;
      end
      default: begin
        xe     = x9;
        ye_pre = y8;
      end
    endcase
  end

  assign post = (ye_pre >= rows);
  assign ye   = post ? rows_m1 : ye_pre;

  always_comb begin
    plan_d            = plan_q;
    plan_d.first_col  = cur_col_q;
    plan_d.first_row  = cur_row_q;
    plan_d.first_fg   = 1'b0;
    plan_d.only_first = 1'b0;
    plan_d.pre_scroll = 1'b0;
    plan_d.glyph_en   = 1'b0;
    plan_d.glyph_col  = xb[7:0];
    plan_d.glyph_row  = yb[6:0];
    plan_d.glyph_code = ChSpace;
    plan_d.post_scroll = post;
    plan_d.end_col    = xe[7:0];
    plan_d.end_row    = ye[6:0];
    case (q_op_i.kind)
      OP_TOGGLE: begin
        plan_d.first_fg    = ~shown_q;
        plan_d.only_first  = 1'b1;
        plan_d.post_scroll = 1'b0;
      end
      OP_BACKSPACE: begin
        plan_d.glyph_en = 1'b1;
      end
      OP_PRINT: begin
        plan_d.pre_scroll = pre;
        plan_d.glyph_en   = 1'b1;
        plan_d.glyph_col  = xw[7:0];
        plan_d.glyph_row  = yg[6:0];
        plan_d.glyph_code = q_op_i.glyph;
      end
      default: ;
    endcase
  end

  // sequencer
  assign out_free = ~out_valid_q | pop_i;
  assign busy     = (phase_q != PH_IDLE);
  assign advance  = busy & out_free;
  assign cur_last = ((phase_q == PH_FIRST) && plan_q.only_first) || (phase_q == PH_CURSOR);
  assign load     = ~q_stat_i.empty & (~busy | (advance & cur_last));
  assign q_rd_o   = load;

  assign after_glyph = plan_q.post_scroll ? PH_POST : PH_CURSOR;
  assign after_first = plan_q.pre_scroll ? PH_PRE :
                       plan_q.glyph_en   ? PH_GLYPH : after_glyph;

  always_comb begin
    cur_draw.cmd   = CMD_FILL;
    cur_draw.col   = 8'd0;
    cur_draw.row   = 7'd0;
    cur_draw.glyph = 8'd0;
    cur_draw.color = cfg_i.bg;
    cur_draw.last  = cur_last;
    phase_d        = phase_q;
    case (phase_q)
      PH_FIRST: begin
        cur_draw.col   = plan_q.first_col;
        cur_draw.row   = plan_q.first_row;
        cur_draw.color = plan_q.first_fg ? cfg_i.fg : cfg_i.bg;
        if (advance) begin
          phase_d = cur_last ? PH_IDLE : after_first;
        end
      end
      PH_PRE: begin
        cur_draw.cmd = CMD_SCROLL;
        if (advance) begin
          phase_d = PH_GLYPH;
        end
      end
      PH_GLYPH: begin
        cur_draw.cmd   = CMD_GLYPH;
        cur_draw.col   = plan_q.glyph_col;
        cur_draw.row   = plan_q.glyph_row;
        cur_draw.glyph = plan_q.glyph_code;
        cur_draw.color = cfg_i.fg;
        if (advance) begin
          phase_d = after_glyph;
        end
      end
      PH_POST: begin
        cur_draw.cmd = CMD_SCROLL;
        if (advance) begin
          phase_d = PH_CURSOR;
        end
      end
      PH_CURSOR: begin
        cur_draw.col   = plan_q.end_col;
        cur_draw.row   = plan_q.end_row;
        cur_draw.color = cfg_i.fg;
        if (advance) begin
          phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (load) begin
      phase_d = PH_FIRST;
    end
  end

  // cursor state moves when an operation is planned
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    shown_d   = shown_q;
    if (load) begin
      if (q_op_i.kind == OP_TOGGLE) begin
        shown_d = ~shown_q;
      end else begin
        cur_col_d = xe[7:0];
        cur_row_d = ye[6:0];
        shown_d   = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cur_col_q   <= 8'd0;
      cur_row_q   <= 7'd0;
      shown_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plan_q <= plan_d;
    end
    if (advance) begin
      out_q <= cur_draw;
    end
  end

  assign out_valid_o = out_valid_q;
  assign draw_o      = out_q;

endmodule

`default_nettype wire

[hw/rtl/text_console_cursor_engine.sv]
// Text console cursor engine: an input word is written into the queue, then
// loaded into the back end's plan register; each of its draw commands then
// passes through the output register. Results leave one per cycle while the
// consumer pops; a word causes 1 to 4 draw commands, set by the sequencer.
// Asynchronous active-low reset: cursor at column 0 row 0 hidden, queue and
// output empty, registers at their defaults. Depends on tcc_pkg.
`default_nettype none

module text_console_cursor_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [7:0]  glyph_code_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       command_o,
  output logic [7:0]       cell_column_o,
  output logic [6:0]       cell_row_o,
  output logic [7:0]       glyph_out_o,
  output logic [31:0]      fill_color_o,
  output logic             last_command_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcc_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  op_t     wr_op, rd_op;
  logic    q_wr, q_rd;
  logic    out_valid;
  draw_t   draw;

  tcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcc_front u_front (
    .push         (push),
    .mode_i       (mode_i),
    .glyph_code_i (glyph_code_i),
    .q_stat_i     (q_stat),
    .full         (full),
    .q_wr_o       (q_wr),
    .q_op_o       (wr_op)
  );

  tcc_op_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wr_op_i (wr_op),
    .rd_i    (q_rd),
    .rd_op_o (rd_op),
    .stat_o  (q_stat)
  );

  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_stat_i    (q_stat),
    .q_op_i      (rd_op),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .draw_o      (draw)
  );

  assign empty          = ~out_valid;
  assign command_o      = draw.cmd;
  assign cell_column_o  = draw.col;
  assign cell_row_o     = draw.row;
  assign glyph_out_o    = draw.glyph;
  assign fill_color_o   = draw.color;
  assign last_command_o = draw.last;

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_stat.empty)
    else $error("back end read an empty queue");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_stat.full)
    else $error("front end wrote a full queue");

  a_scroll_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_o == CMD_SCROLL) |->
      (fill_color_o == cfg.bg && cell_column_o == 8'd0 && !last_command_o))
    else $error("scroll word malformed");

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for text_console_cursor_engine: queue-style input and result ports plus APB writes.
// A scoreboard class predicts the draw commands for every accepted word. Depends on tcc_pkg.
module tb;
  import tcc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ReportLimit = 10;
  localparam logic ModePut = 1'b0;
  localparam logic ModeToggle = 1'b1;

  class draw_scoreboard;
    logic [8:0] column_count;
    logic [7:0] row_count;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [7:0] cur_col;
    logic [6:0] cur_row;
    bit shown;
    draw_t expected_draws[$];
    int unsigned fail_count;
    int unsigned report_count;

    function new();
      column_count = ColumnCountReset;
      row_count = RowCountReset;
      fg = ForegroundReset;
      bg = BackgroundReset;
      cur_col = '0;
      cur_row = '0;
      shown = 1'b0;
      fail_count = 0;
      report_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegColumnCount: column_count = value[8:0];
        RegRowCount: row_count = value[7:0];
        RegForeground: fg = value;
        RegBackground: bg = value;
        default: ;
      endcase
    endfunction

    function void queue_draw(cmd_e cmd, int x, int y, logic [7:0] glyph, logic [31:0] color,
                             bit last);
      draw_t d;
      d.cmd = cmd;
      d.col = x[7:0];
      d.row = y[6:0];
      d.glyph = glyph;
      d.color = color;
      d.last = last;
      expected_draws.push_back(d);
    endfunction

    // Accepted input word: work out the draw commands it causes.
    function void note_word(logic m, logic [7:0] ch);
      int cols, rows, x, y;
      cols = (column_count == 0) ? 1 : (column_count > MaxColumns) ? MaxColumns : column_count;
      rows = (row_count == 0) ? 1 : (row_count > MaxRows) ? MaxRows : row_count;
      x = cur_col;
      y = cur_row;
      if (m == ModeToggle) begin
        shown = !shown;
        queue_draw(CMD_FILL, x, y, 8'd0, shown ? fg : bg, 1'b1);
        return;
      end
      queue_draw(CMD_FILL, x, y, 8'd0, bg, 1'b0);
      if (ch == ChNewline) begin
        x = 0;
        y++;
      end else if (ch == ChReturn) begin
        x = 0;
      end else if (ch == ChBackspace) begin
        if (x > 0) begin
          x--;
        end else if (y > 0) begin
          y--;
          x = cols - 1;
        end
        queue_draw(CMD_GLYPH, x, y, ChSpace, fg, 1'b0);
      end else begin
        if (x >= cols - 1) begin
          x = 0;
          y++;
        end
        // scroll before the glyph so it never lands below the last row
        if (y >= rows) begin
          queue_draw(CMD_SCROLL, 0, 0, 8'd0, bg, 1'b0);
          y = rows - 1;
        end
        queue_draw(CMD_GLYPH, x, y, ch, fg, 1'b0);
        x++;
      end
      if (y >= rows) begin
        queue_draw(CMD_SCROLL, 0, 0, 8'd0, bg, 1'b0);
        y = rows - 1;
      end
      queue_draw(CMD_FILL, x, y, 8'd0, fg, 1'b1);
      cur_col = x[7:0];
      cur_row = y[6:0];
      shown = 1'b1;
    endfunction

    function void check_draw(logic [1:0] cmd, logic [7:0] col, logic [6:0] row,
                             logic [7:0] glyph, logic [31:0] color, logic last);
      draw_t e;
      if (expected_draws.size() == 0) begin
        fail_count++;
        if (report_count < ReportLimit) begin
          report_count++;
          $display("unexpected word: cmd=%0d col=%0d row=%0d glyph=%02h color=%08h last=%0b",
                   cmd, col, row, glyph, color, last);
        end
        return;
      end
      e = expected_draws.pop_front();
      if (cmd !== e.cmd || col !== e.col || row !== e.row || glyph !== e.glyph ||
          color !== e.color || last !== e.last) begin
        fail_count++;
        if (report_count < ReportLimit) begin
          report_count++;
          $display("mismatch: exp cmd=%0d col=%0d row=%0d glyph=%02h color=%08h last=%0b",
                   e.cmd, e.col, e.row, e.glyph, e.color, e.last);
          $display("          got cmd=%0d col=%0d row=%0d glyph=%02h color=%08h last=%0b",
                   cmd, col, row, glyph, color, last);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic mode_i;
  logic [7:0] glyph_code_i;
  logic empty;
  logic pop;
  logic [1:0] command_o;
  logic [7:0] cell_column_o;
  logic [6:0] cell_row_o;
  logic [7:0] glyph_out_o;
  logic [31:0] fill_color_o;
  logic last_command_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  draw_scoreboard sb = new();

  int in_left = 0;
  bit in_quiet = 1'b0;
  int out_left = 0;
  bit out_quiet = 1'b0;

  text_console_cursor_engine dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .mode_i(mode_i),
    .glyph_code_i(glyph_code_i),
    .empty(empty),
    .pop(pop),
    .command_o(command_o),
    .cell_column_o(cell_column_o),
    .cell_row_o(cell_row_o),
    .glyph_out_o(glyph_out_o),
    .fill_color_o(fill_color_o),
    .last_command_o(last_command_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap per word; each run of words has either random gaps or none at all.
  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      left = $urandom_range(4, 24);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_word(logic m, logic [7:0] ch);
    int gap;
    gap = draw_gap(in_left, in_quiet);
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      mode_i <= 1'($urandom_range(0, 1));
      glyph_code_i <= 8'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    mode_i <= m;
    glyph_code_i <= ch;
    do @(posedge clk_i); while (full);
    sb.note_word(m, ch);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) send_word(ModeToggle, 8'($urandom_range(0, 255)));
    else if (r < 25) send_word(ModePut, ChNewline);
    else if (r < 33) send_word(ModePut, ChReturn);
    else if (r < 45) send_word(ModePut, ChBackspace);
    else send_word(ModePut, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stop pushing and wait until every predicted word has come out.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.expected_draws.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(logic [8:0] cols, logic [7:0] rows, logic [31:0] fg,
                           logic [31:0] bg);
    drain();
    write_reg(RegColumnCount, {23'd0, cols});
    write_reg(RegRowCount, {24'd0, rows});
    write_reg(RegForeground, fg);
    write_reg(RegBackground, bg);
  endtask

  initial begin : pop_side
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(out_left, out_quiet);
      if (gap > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_draw(command_o, cell_column_o, cell_row_o, glyph_out_o, fill_color_o,
                    last_command_o);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [8:0] cols;
    logic [7:0] rows;
    logic [31:0] fg;
    logic [31:0] bg;
    rst_ni = 1'b0;
    push = 1'b0;
    mode_i = 1'b0;
    glyph_code_i = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset grid: backspace at origin, both toggle directions, byte extremes
    send_word(ModePut, ChBackspace);
    send_word(ModeToggle, 8'hff);
    send_word(ModeToggle, 8'h00);
    send_word(ModePut, 8'h41);
    send_word(ModePut, 8'h00);
    send_word(ModePut, 8'hff);
    send_word(ModePut, 8'h7f);
    send_word(ModePut, ChBackspace);
    send_word(ModePut, ChReturn);
    send_word(ModePut, ChNewline);
    send_word(ModePut, ChBackspace);

    // single cell: every printable wraps and scrolls
    configure(9'd1, 8'd1, 32'h0000_0000, 32'hffff_ffff);
    send_word(ModePut, 8'h78);
    send_word(ModePut, 8'h79);
    send_word(ModePut, ChNewline);
    send_word(ModePut, ChBackspace);
    send_word(ModePut, ChBackspace);
    send_word(ModeToggle, 8'h5a);

    // park the cursor, then shrink the grid under it
    configure(9'd256, 8'd128, 32'hffff_ffff, 32'h0000_0000);
    repeat (3) send_word(ModePut, ChNewline);
    repeat (5) send_word(ModePut, 8'h2a);
    configure(9'd4, 8'd3, 32'h1234_5678, 32'h8765_4321);
    send_word(ModePut, 8'h7a);
    send_word(ModePut, ChBackspace);

    for (int p = 0; p < 8; p++) begin
      fg = $urandom;
      bg = $urandom;
      case (p)
        0: begin cols = 9'd0; rows = 8'd0; fg = 32'h0; bg = 32'hffff_ffff; end
        1: begin cols = 9'd511; rows = 8'd255; fg = 32'hffff_ffff; bg = 32'h0; end
        2: begin cols = 9'd256; rows = 8'd128; end
        3: begin cols = 9'd1; rows = 8'($urandom_range(1, 6)); end
        4: begin cols = 9'($urandom_range(2, 12)); rows = 8'd1; end
        default: begin
          cols = 9'($urandom_range(1, 12));
          rows = 8'($urandom_range(1, 6));
        end
      endcase
      configure(cols, rows, fg, bg);
      repeat (31) send_random();
    end

    drain();
    if (sb.fail_count == 0 && sb.expected_draws.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_cfg_regs.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_op_queue.sv
hw/rtl/tcc_back.sv
hw/rtl/text_console_cursor_engine.sv
dv/tb.sv
